// File: hdl/conv2d_multichannel_forward_defines.svh
// Assertion macros for the conv2d_multichannel_forward block.
// Used by conv2d_multichannel_forward.sv; depends on clk and rst_n being in scope.
`ifndef CONV2D_MULTICHANNEL_FORWARD_DEFINES_SVH
`define CONV2D_MULTICHANNEL_FORWARD_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define CV2D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CV2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CV2D_ASSERT_NOW(lbl, ante, cons)
`define CV2D_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/cv2d_pkg.sv
// Shared types and codes for the 3x3 multichannel convolution block.
// No dependencies.
`default_nettype none
package cv2d_pkg;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    localparam logic [1:0] CFG_INPUT_CHANNELS  = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_CHANNELS = 2'd1;
    localparam logic [1:0] CFG_FRAME_WIDTH     = 2'd2;
    localparam logic [1:0] CFG_FRAME_HEIGHT    = 2'd3;

    localparam int MAX_HEIGHT = 1024;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    typedef struct packed {
        logic weight_we;
        logic bias_we;
    } load_t;

endpackage
`default_nettype wire

// File: hdl/cv2d_line_store.sv
// Line store: the last K rows of samples, all channels.
// One write port, one registered read port. Uses cv2d_pkg.
`default_nettype none
module cv2d_line_store #(
    parameter int DEPTH = 98304,
    parameter int AW    = 17
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic signed [15:0]   wdata,
    input  wire logic [AW-1:0]        raddr,
    output logic signed [15:0]        rdata
);
    import cv2d_pkg::*;

    logic signed [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hdl/cv2d_coef_store.sv
// Weight and bias stores with registered reads.
// Uses cv2d_pkg (load_t).
`default_nettype none
module cv2d_coef_store #(
    parameter int WDEPTH = 9216,
    parameter int WAW    = 14,
    parameter int BDEPTH = 32,
    parameter int BAW    = 5
) (
    input  wire logic                 clk,
    input  cv2d_pkg::load_t           load,
    input  wire logic [WAW-1:0]       load_waddr,
    input  wire logic [BAW-1:0]       load_baddr,
    input  wire logic signed [31:0]   load_data,
    input  wire logic [WAW-1:0]       weight_raddr,
    input  wire logic [BAW-1:0]       bias_raddr,
    output logic signed [15:0]        weight_rdata,
    output logic signed [31:0]        bias_rdata
);
    import cv2d_pkg::*;

    logic signed [15:0] weight_mem [WDEPTH];
    logic signed [31:0] bias_mem [BDEPTH];

    always_ff @(posedge clk)
    begin
        if (load.weight_we)
        begin
            weight_mem[load_waddr] <= load_data[15:0];
        end
        weight_rdata <= weight_mem[weight_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (load.bias_we)
        begin
            bias_mem[load_baddr] <= load_data;
        end
        bias_rdata <= bias_mem[bias_raddr];
    end

endmodule
`default_nettype wire

// File: hdl/conv2d_multichannel_forward.sv
// Valid-mode KxK multichannel convolution: position counters, MAC sequencer
// and output register. Uses cv2d_pkg, cv2d_line_store, cv2d_coef_store.
//
// Usage:
//  - Input channel (in_valid/in_ready): op selects a weight load, a bias load
//    or one sample. Samples come in raster order, channels innermost.
//  - Config port: write_enable/write_index/write_data, taken at once; write it only
//    while the block is idle (the block itself does not enforce this).
//  - Output channel (out_valid/out_ready): when the last channel of pixel
//    (x,y) arrives with x,y >= K-1, one result per output channel follows
//    for position (x-K+1, y-K+1), with last set on the final channel.
//  - Loads and samples that start no window leave in_ready high. For each output
//    channel of a window, one MAC reads one sample and one weight from the
//    stores each cycle, then the pipeline drains and the result is handed to
//    the output register.
//  - in_ready is low while a window is computed. If the receiver stalls,
//    the finished result waits in the accumulator, and the next output
//    channel starts only once the output register frees; a new transaction
//    is still taken once the last result is in the output register.
//  - Reset clears counters and config to defaults; the stores hold no
//    defined value until written.
`default_nettype none
module conv2d_multichannel_forward #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_IN_CH   = 32,
    parameter int MAX_OUT_CH  = 32,
    parameter int WIN_DIM     = 3
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 write_enable,
    input  wire logic [1:0]           write_index,
    input  wire logic [10:0]          write_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           op,
    input  wire logic [13:0]          address,
    input  wire logic signed [31:0]   coefficient,
    input  wire logic signed [15:0]   sample,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [9:0]                out_x,
    output logic [9:0]                out_y,
    output logic [4:0]                out_channel,
    output logic signed [31:0]        value,
    output logic                      last
);
    import cv2d_pkg::*;
    `include "conv2d_multichannel_forward_defines.svh"

    localparam int K      = WIN_DIM;
    localparam int WDEPTH = K * K * MAX_IN_CH * MAX_OUT_CH;
    localparam int RDEPTH = K * MAX_WIDTH * MAX_IN_CH;
    localparam int WAW    = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
    localparam int RAW    = RDEPTH > 1 ? $clog2(RDEPTH) : 1;
    localparam int BAW    = MAX_OUT_CH > 1 ? $clog2(MAX_OUT_CH) : 1;
    localparam int KW     = $clog2(K + 1);
    localparam int ICW    = $clog2(MAX_IN_CH + 1);
    localparam int OCW    = $clog2(MAX_OUT_CH + 1);
    localparam int XW     = $clog2(MAX_WIDTH + 1);
    localparam int AW     = 34 + $clog2(MAX_IN_CH * K * K + 1);

    // configuration
    logic [5:0]  in_ch_cfg_reg, out_ch_cfg_reg;
    logic [10:0] fw_cfg_reg, fh_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_cfg_reg  <= 6'd3;
            out_ch_cfg_reg <= 6'd32;
            fw_cfg_reg     <= 11'd640;
            fh_cfg_reg     <= 11'd480;
        end
        else if (write_enable)
        begin
            case (write_index)
                CFG_INPUT_CHANNELS:  in_ch_cfg_reg  <= write_data[5:0];
                CFG_OUTPUT_CHANNELS: out_ch_cfg_reg <= write_data[5:0];
                CFG_FRAME_WIDTH:     fw_cfg_reg     <= write_data;
                CFG_FRAME_HEIGHT:    fh_cfg_reg     <= write_data;
                default: ;
            endcase
        end
    end

    logic [ICW-1:0] in_ch;
    logic [OCW-1:0] out_ch;
    logic [XW-1:0]  width;
    logic [10:0]    height;

    always_comb
    begin
        if (in_ch_cfg_reg == 6'd0)
            in_ch = ICW'(1);
        else if (int'(in_ch_cfg_reg) > MAX_IN_CH)
            in_ch = ICW'(MAX_IN_CH);
        else
            in_ch = ICW'(in_ch_cfg_reg);

        if (out_ch_cfg_reg == 6'd0)
            out_ch = OCW'(1);
        else if (int'(out_ch_cfg_reg) > MAX_OUT_CH)
            out_ch = OCW'(MAX_OUT_CH);
        else
            out_ch = OCW'(out_ch_cfg_reg);

        if (int'(fw_cfg_reg) < K)
            width = XW'(K);
        else if (int'(fw_cfg_reg) > MAX_WIDTH)
            width = XW'(MAX_WIDTH);
        else
            width = XW'(fw_cfg_reg);

        if (int'(fh_cfg_reg) < K)
            height = 11'(K);
        else if (int'(fh_cfg_reg) > MAX_HEIGHT)
            height = 11'(MAX_HEIGHT);
        else
            height = fh_cfg_reg;
    end

    // control state
    state_t         state_reg, state_next;
    logic [XW-1:0]  col_reg, col_next, x0_reg, x0_next;
    logic [9:0]     row_reg, row_next, y0_reg, y0_next;
    logic [KW-1:0]  yslot_reg, yslot_next, base_reg, base_next;
    logic [KW-1:0]  rslot_reg, rslot_next, kx_reg, kx_next, ky_reg, ky_next;
    logic [ICW-1:0] cc_reg, cc_next, ic_reg, ic_next;
    logic [OCW-1:0] oc_reg, oc_next;
    logic [WAW-1:0] wptr_reg, wptr_next;

    // pipeline
    logic                  v1_reg, first1_reg, last1_reg;
    logic                  v2_reg, first2_reg, last2_reg;
    logic signed [31:0]    bias2_reg, prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic                  done_reg, done_next;
    logic                  out_valid_reg, out_valid_next;
    logic [9:0]            out_x_reg, out_y_reg;
    logic [4:0]            out_channel_reg;
    logic signed [31:0]    value_reg;
    logic                  last_reg;

    logic accept, is_sample, issue, tap_first, tap_last, out_free, load_out;
    logic last_ch;
    logic [XW-1:0]  x;
    logic [XW:0]    x_inc;
    logic [9:0]     y;
    logic [10:0]    y_inc;
    logic [KW-1:0]  ys, ys_inc;
    load_t          load;
    logic [RAW-1:0] row_waddr, row_raddr;
    logic signed [15:0] row_rdata, weight_rdata;
    logic signed [31:0] bias_rdata;
    logic signed [AW-1:0] acc_sat;
    logic signed [31:0] sat_value;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_sample = accept && (op == OP_SAMPLE);
    assign issue     = (state_reg == ST_RUN);
    assign tap_first = (kx_reg == '0) && (ky_reg == '0) && (ic_reg == '0);
    assign tap_last  = (kx_reg == KW'(K - 1)) && (ky_reg == KW'(K - 1))
                       && (ic_reg == in_ch - ICW'(1));
    assign out_free  = !out_valid_reg || out_ready;
    assign load_out  = done_reg && out_free;

    assign load.weight_we = accept && (op == OP_WEIGHT) && (int'(address) < WDEPTH);
    assign load.bias_we   = accept && (op == OP_BIAS) && (int'(address) < MAX_OUT_CH);

    // position of the incoming sample; a count left beyond its bound wraps
    always_comb
    begin
        x = (col_reg >= width) ? '0 : col_reg;
        if ({1'b0, row_reg} >= height)
        begin
            y  = '0;
            ys = '0;
        end
        else
        begin
            y  = row_reg;
            ys = yslot_reg;
        end
        x_inc   = {1'b0, x} + (XW + 1)'(1);
        y_inc   = {1'b0, y} + 11'd1;
        ys_inc  = (ys == KW'(K - 1)) ? '0 : ys + KW'(1);
        last_ch = ({1'b0, cc_reg} + (ICW + 1)'(1)) >= {1'b0, in_ch};
    end

    assign row_waddr = RAW'((int'(ys) * MAX_WIDTH + int'(x)) * MAX_IN_CH + int'(cc_reg));
    assign row_raddr = RAW'((int'(rslot_reg) * MAX_WIDTH + int'(x0_reg) + int'(kx_reg))
                            * MAX_IN_CH + int'(ic_reg));

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        yslot_next = yslot_reg;
        cc_next    = cc_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        base_next  = base_reg;
        rslot_next = rslot_reg;
        kx_next    = kx_reg;
        ky_next    = ky_reg;
        ic_next    = ic_reg;
        oc_next    = oc_reg;
        wptr_next  = wptr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_sample)
                begin
                    col_next   = x;
                    row_next   = y;
                    yslot_next = ys;
                    if (last_ch)
                    begin
                        cc_next = '0;
                        if (x_inc >= {1'b0, width})
                        begin
                            col_next = '0;
                            if (y_inc >= height)
                            begin
                                row_next   = '0;
                                yslot_next = '0;
                            end
                            else
                            begin
                                row_next   = y_inc[9:0];
                                yslot_next = ys_inc;
                            end
                        end
                        else
                        begin
                            col_next = x_inc[XW-1:0];
                        end
                        if (int'(x) >= K - 1 && int'(y) >= K - 1)
                        begin
                            // slot of the window's top row is (y - K + 1) mod K
                            x0_next    = x - XW'(K - 1);
                            y0_next    = y - 10'(K - 1);
                            base_next  = ys_inc;
                            rslot_next = ys_inc;
                            kx_next    = '0;
                            ky_next    = '0;
                            ic_next    = '0;
                            oc_next    = '0;
                            wptr_next  = '0;
                            state_next = ST_RUN;
                        end
                    end
                    else
                    begin
                        cc_next = cc_reg + ICW'(1);
                    end
                end
            end
            ST_RUN:
            begin
                wptr_next = wptr_reg + WAW'(1);
                if (kx_reg == KW'(K - 1))
                begin
                    kx_next = '0;
                    if (ky_reg == KW'(K - 1))
                    begin
                        ky_next    = '0;
                        rslot_next = base_reg;
                        ic_next    = ic_reg + ICW'(1);
                    end
                    else
                    begin
                        ky_next    = ky_reg + KW'(1);
                        rslot_next = (rslot_reg == KW'(K - 1)) ? '0 : rslot_reg + KW'(1);
                    end
                end
                else
                begin
                    kx_next = kx_reg + KW'(1);
                end
                if (tap_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (load_out)
                begin
                    kx_next    = '0;
                    ky_next    = '0;
                    ic_next    = '0;
                    rslot_next = base_reg;
                    if (oc_reg == out_ch - OCW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        oc_next    = oc_reg + OCW'(1);
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (acc_reg > AW'(32'sh7FFFFFFF))
            acc_sat = AW'(32'sh7FFFFFFF);
        else if (acc_reg < AW'(32'sh80000000))
            acc_sat = AW'(32'sh80000000);
        else
            acc_sat = acc_reg;
        sat_value = acc_sat[31:0];
    end

    assign done_next      = (v2_reg && last2_reg) ? 1'b1 : (load_out ? 1'b0 : done_reg);
    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            yslot_reg     <= '0;
            cc_reg        <= '0;
            x0_reg        <= '0;
            y0_reg        <= '0;
            base_reg      <= '0;
            rslot_reg     <= '0;
            kx_reg        <= '0;
            ky_reg        <= '0;
            ic_reg        <= '0;
            oc_reg        <= '0;
            wptr_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            yslot_reg     <= yslot_next;
            cc_reg        <= cc_next;
            x0_reg        <= x0_next;
            y0_reg        <= y0_next;
            base_reg      <= base_next;
            rslot_reg     <= rslot_next;
            kx_reg        <= kx_next;
            ky_reg        <= ky_next;
            ic_reg        <= ic_next;
            oc_reg        <= oc_next;
            wptr_reg      <= wptr_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath: store read, multiply, accumulate
    always_ff @(posedge clk)
    begin
        first1_reg <= tap_first;
        last1_reg  <= tap_last;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        bias2_reg  <= bias_rdata;
        prod_reg   <= row_rdata * weight_rdata;
        if (v2_reg)
        begin
            if (first2_reg)
                acc_reg <= AW'(bias2_reg) + AW'(prod_reg);
            else
                acc_reg <= acc_reg + AW'(prod_reg);
        end
        if (load_out)
        begin
            out_x_reg       <= 10'(x0_reg);
            out_y_reg       <= y0_reg;
            out_channel_reg <= 5'(oc_reg);
            value_reg       <= sat_value;
            last_reg        <= (oc_reg == out_ch - OCW'(1));
        end
    end

    cv2d_line_store #(
        .DEPTH (RDEPTH),
        .AW    (RAW)
    ) u_line_store (
        .clk   (clk),
        .we    (is_sample),
        .waddr (row_waddr),
        .wdata (sample),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    cv2d_coef_store #(
        .WDEPTH (WDEPTH),
        .WAW    (WAW),
        .BDEPTH (MAX_OUT_CH),
        .BAW    (BAW)
    ) u_coef_store (
        .clk          (clk),
        .load         (load),
        .load_waddr   (WAW'(address)),
        .load_baddr   (BAW'(address)),
        .load_data    (coefficient),
        .weight_raddr (wptr_reg),
        .bias_raddr   (BAW'(oc_reg)),
        .weight_rdata (weight_rdata),
        .bias_rdata   (bias_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_channel = out_channel_reg;
    assign value       = value_reg;
    assign last        = last_reg;

    `CV2D_ASSERT_NOW(a_done_in_wait, done_reg, state_reg == ST_WAIT)
    `CV2D_ASSERT_NOW(a_pipe_busy, v1_reg || v2_reg, state_reg == ST_RUN || state_reg == ST_WAIT)
    `CV2D_ASSERT_NEXT(a_last_frees_input, load_out && (oc_reg == out_ch - OCW'(1)), in_ready && out_valid && last)

endmodule
`default_nettype wire

// File: tb/conv2d_multichannel_forward_tb.sv
// Self-checking testbench for the 3x3 multichannel valid convolution block.
// Depends on cv2d_pkg and conv2d_multichannel_forward; drives random and directed traffic.
`default_nettype none
module conv2d_multichannel_forward_tb;
    import cv2d_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int K = 3;
    localparam int W_MAX = 1024;
    localparam int IC_MAX = 32;
    localparam int OC_MAX = 32;
    localparam int KERNEL_DEPTH = K * K * IC_MAX * OC_MAX;
    localparam int LINE_DEPTH = K * W_MAX * IC_MAX;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [9:0]         x;
        logic [9:0]         y;
        logic [4:0]         ch;
        logic signed [31:0] val;
        logic               lst;
    } conv_result_t;

    typedef struct {
        logic [1:0]         op;
        logic [13:0]        addr;
        logic signed [31:0] coef;
        logic signed [15:0] smp;
        bit                 has_exp;
        logic signed [31:0] exp_val;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic write_enable;
    logic [1:0] write_index;
    logic [10:0] write_data;
    logic in_valid;
    logic in_ready;
    logic [1:0] op;
    logic [13:0] address;
    logic signed [31:0] coefficient;
    logic signed [15:0] sample;
    logic out_valid;
    logic out_ready;
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic [4:0] out_channel;
    logic signed [31:0] value;
    logic last;

    conv2d_multichannel_forward DUT (
        .clk(clk),
        .rst_n(rst_n),
        .write_enable(write_enable),
        .write_index(write_index),
        .write_data(write_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .address(address),
        .coefficient(coefficient),
        .sample(sample),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_x(out_x),
        .out_y(out_y),
        .out_channel(out_channel),
        .value(value),
        .last(last)
    );

    // predictor state
    logic signed [15:0] kernel_mem [KERNEL_DEPTH];
    logic signed [31:0] bias_mem [OC_MAX];
    logic signed [15:0] line_mem [LINE_DEPTH];
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned chan_cnt;
    logic [5:0] reg_in_ch;
    logic [5:0] reg_out_ch;
    logic [10:0] reg_width;
    logic [10:0] reg_height;

    conv_result_t pending_results[$];
    int error_count;
    int idle_mode;
    bit hold_off_req;
    int quiet_cycles;

    directed_row_t directed_rows[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic int unsigned clamp_val(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the predictor by one accepted transaction and queue its results.
    function automatic void predict_convolution(logic [1:0] p_op, logic [13:0] p_addr,
                                                logic signed [31:0] p_coef,
                                                logic signed [15:0] p_smp);
        int unsigned n_in;
        int unsigned n_out;
        int unsigned wd;
        int unsigned ht;
        int unsigned x0;
        int unsigned y0;
        int unsigned ch;
        int unsigned si;
        int unsigned wi;
        bit last_ch;
        longint acc;
        conv_result_t r;
        n_in = clamp_val(reg_in_ch, 1, IC_MAX);
        n_out = clamp_val(reg_out_ch, 1, OC_MAX);
        wd = clamp_val(reg_width, K, W_MAX);
        ht = clamp_val(reg_height, K, 1024);
        if (p_op == OP_WEIGHT)
        begin
            if (p_addr < KERNEL_DEPTH)
                kernel_mem[p_addr] = p_coef[15:0];
            return;
        end
        if (p_op == OP_BIAS)
        begin
            if (p_addr < OC_MAX)
                bias_mem[p_addr] = p_coef;
            return;
        end
        if (p_op != OP_SAMPLE)
            return;
        if (col_cnt >= wd)
            col_cnt = 0;
        if (row_cnt >= ht)
            row_cnt = 0;
        ch = (chan_cnt < IC_MAX) ? chan_cnt : IC_MAX - 1;
        line_mem[((row_cnt % K) * W_MAX + col_cnt) * IC_MAX + ch] = p_smp;
        last_ch = (chan_cnt + 1 >= n_in);
        if (last_ch && col_cnt >= K - 1 && row_cnt >= K - 1)
        begin
            x0 = col_cnt - (K - 1);
            y0 = row_cnt - (K - 1);
            for (int unsigned oc = 0; oc < n_out; oc++)
            begin
                acc = bias_mem[oc];
                for (int unsigned ic = 0; ic < n_in; ic++)
                    for (int unsigned ky = 0; ky < K; ky++)
                        for (int unsigned kx = 0; kx < K; kx++)
                        begin
                            si = (((y0 + ky) % K) * W_MAX + x0 + kx) * IC_MAX + ic;
                            wi = kx + K * ky + K * K * ic + K * K * n_in * oc;
                            if (si < LINE_DEPTH && wi < KERNEL_DEPTH)
                                acc += longint'(line_mem[si]) * longint'(kernel_mem[wi]);
                        end
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
                if (acc < -64'sd2147483648)
                    acc = -64'sd2147483648;
                r.x = x0[9:0];
                r.y = y0[9:0];
                r.ch = oc[4:0];
                r.val = acc[31:0];
                r.lst = (oc + 1 == n_out);
                pending_results.push_back(r);
            end
        end
        if (last_ch)
        begin
            chan_cnt = 0;
            col_cnt++;
            if (col_cnt >= wd)
            begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= ht)
                    row_cnt = 0;
            end
        end
        else
            chan_cnt++;
    endfunction

    function automatic int sender_idle_pct();
        return (idle_mode == 0) ? 32 : (idle_mode == 1) ? 59 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        return (idle_mode == 0) ? 59 : (idle_mode == 1) ? 32 : 0;
    endfunction

    // Offer one transaction and hold it until accepted; called at a falling edge.
    task automatic send_item(logic [1:0] p_op, logic [13:0] p_addr, logic signed [31:0] p_coef,
                             logic signed [15:0] p_smp);
        while ($urandom_range(99) < sender_idle_pct())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        op = p_op;
        address = p_addr;
        coefficient = p_coef;
        sample = p_smp;
        do
            @(posedge clk);
        while (!in_ready);
        predict_convolution(p_op, p_addr, p_coef, p_smp);
        @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [10:0] data);
        in_valid = 1'b0;
        write_enable = 1'b1;
        write_index = idx;
        write_data = data;
        case (idx)
            CFG_INPUT_CHANNELS:  reg_in_ch = data[5:0];
            CFG_OUTPUT_CHANNELS: reg_out_ch = data[5:0];
            CFG_FRAME_WIDTH:     reg_width = data;
            default:             reg_height = data;
        endcase
        @(negedge clk);
        write_enable = 1'b0;
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_frame(logic [10:0] ic, logic [10:0] oc, logic [10:0] wd, logic [10:0] ht);
        write_register(CFG_INPUT_CHANNELS, ic);
        write_register(CFG_OUTPUT_CHANNELS, oc);
        write_register(CFG_FRAME_WIDTH, wd);
        write_register(CFG_FRAME_HEIGHT, ht);
    endtask

    // Load every weight and bias the current frame reads, then send one whole
    // frame so the position counters end at zero; sprinkle in coefficient
    // reloads and ignored transactions. Optionally start the receiver hold-off
    // once the samples begin.
    task automatic random_frame(int noise_pct, bit hold);
        int unsigned n_in;
        int unsigned n_out;
        int unsigned n_samples;
        int unsigned pick;
        n_in = clamp_val(reg_in_ch, 1, IC_MAX);
        n_out = clamp_val(reg_out_ch, 1, OC_MAX);
        for (int unsigned i = 0; i < K * K * n_in * n_out; i++)
            send_item(OP_WEIGHT, 14'(i), 32'($urandom), 16'($urandom));
        for (int unsigned i = 0; i < n_out; i++)
            send_item(OP_BIAS, 14'(i), 32'($urandom), '0);
        if (hold)
            hold_off_req = 1'b1;
        n_samples = clamp_val(reg_width, K, W_MAX) * clamp_val(reg_height, K, 1024) * n_in;
        for (int unsigned i = 0; i < n_samples; i++)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                pick = $urandom_range(3);
                case (pick)
                    0: send_item(OP_WEIGHT, 14'($urandom_range(16383)), 32'($urandom),
                                 16'($urandom));
                    1: send_item(OP_BIAS, 14'($urandom_range(63)), 32'($urandom),
                                 16'($urandom));
                    2: send_item(OP_UNUSED, 14'($urandom_range(16383)), 32'($urandom),
                                 16'($urandom));
                    default: send_item(OP_BIAS, 14'($urandom_range(OC_MAX - 1)), 32'($urandom),
                                       16'($urandom));
                endcase
            end
            send_item(OP_SAMPLE, 14'($urandom_range(16383)), 32'($urandom), 16'($urandom));
        end
    endtask

    function automatic void add_row(logic [1:0] p_op, logic [13:0] p_addr,
                                    logic signed [31:0] p_coef, logic signed [15:0] p_smp,
                                    bit has_exp, logic signed [31:0] exp_val);
        directed_row_t d;
        d.op = p_op;
        d.addr = p_addr;
        d.coef = p_coef;
        d.smp = p_smp;
        d.has_exp = has_exp;
        d.exp_val = exp_val;
        directed_rows.push_back(d);
    endfunction

    // receiver: random ready, with an optional long hold-off
    initial
    begin
        int hold_count;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready = 1'b0;
                for (hold_count = 0; hold_count < 400; hold_count++)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            out_ready = ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    always @(posedge clk)
    begin
        conv_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result x=%0d y=%0d ch=%0d value=%0d",
                       out_x, out_y, out_channel, value);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_x !== e.x)
                begin
                    $error("out_x expected %0d actual %0d", e.x, out_x);
                    error_count++;
                end
                if (out_y !== e.y)
                begin
                    $error("out_y expected %0d actual %0d", e.y, out_y);
                    error_count++;
                end
                if (out_channel !== e.ch)
                begin
                    $error("out_channel expected %0d actual %0d", e.ch, out_channel);
                    error_count++;
                end
                if (value !== e.val)
                begin
                    $error("value expected %0d actual %0d", e.val, value);
                    error_count++;
                end
                if (last !== e.lst)
                begin
                    $error("last expected %0d actual %0d", e.lst, last);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        conv_result_t typed;
        rst_n = 1'b0;
        write_enable = 1'b0;
        write_index = '0;
        write_data = '0;
        in_valid = 1'b0;
        op = OP_SAMPLE;
        address = '0;
        coefficient = '0;
        sample = '0;
        error_count = 0;
        quiet_cycles = 0;
        hold_off_req = 1'b0;
        idle_mode = 0;
        col_cnt = 0;
        row_cnt = 0;
        chan_cnt = 0;
        reg_in_ch = 6'd3;
        reg_out_ch = 6'd32;
        reg_width = 11'd640;
        reg_height = 11'd480;
        foreach (line_mem[i])
            line_mem[i] = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: one output channel on a 3x3 frame, both saturation limits
        set_frame(11'd1, 11'd1, 11'd3, 11'd3);
        for (int i = 0; i < 9; i++)
            add_row(OP_WEIGHT, 14'(i), 32'sh0000_7FFF, '0, 1'b0, '0);
        add_row(OP_BIAS, 14'd0, 32'sh7FFF_FFFF, '0, 1'b0, '0);
        add_row(OP_BIAS, 14'd32, 32'sh1234_5678, '0, 1'b0, '0);
        add_row(OP_WEIGHT, 14'd16383, '0, '0, 1'b0, '0);
        add_row(OP_UNUSED, 14'd0, -32'sd1, -16'sd1, 1'b0, '0);
        add_row(OP_WEIGHT, 14'd9215, 32'shFFFF_8000, '0, 1'b0, '0);
        for (int i = 0; i < 9; i++)
            add_row(OP_SAMPLE, 14'd0, '0, 16'sh7FFF, i == 8, 32'sh7FFF_FFFF);
        add_row(OP_BIAS, 14'd0, 32'sh8000_0000, '0, 1'b0, '0);
        for (int i = 0; i < 9; i++)
            add_row(OP_SAMPLE, 14'h3FFF, -32'sd1, 16'sh8000, i == 8, 32'sh8000_0000);
        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].coef,
                      directed_rows[i].smp);
            if (directed_rows[i].has_exp)
            begin
                void'(pending_results.pop_back());
                typed.x = '0;
                typed.y = '0;
                typed.ch = '0;
                typed.val = directed_rows[i].exp_val;
                typed.lst = 1'b1;
                pending_results.push_back(typed);
            end
        end
        drain_results();

        set_frame(11'd2, 11'd3, 11'd4, 11'd4);
        random_frame(10, 1'b0);
        drain_results();

        // out-of-range values: only 6 bits of a channel count are kept, zero
        // channels count as one, the frame saturates to 3x3
        idle_mode = 1;
        set_frame(11'd65, 11'd0, 11'd0, 11'd2);
        random_frame(5, 1'b0);
        drain_results();

        // receiver holds off while the sender keeps offering
        set_frame(11'd2, 11'd4, 11'd4, 11'd4);
        random_frame(15, 1'b1);
        drain_results();

        idle_mode = 2;
        set_frame(11'd3, 11'd2, 11'd4, 11'd3);
        random_frame(10, 1'b0);
        drain_results();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
